### sv/rcpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpr_pkg
// Shared types and constants for the RC packet receiver with failsafe.
// ----------------------------------------------------------------------------
package rcpr_pkg;

  localparam int POS_W     = 5;   // byte position within a frame
  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int LOST_W    = 32;
  localparam int NUM_CHANS = 7;   // channels carried by every frame
  localparam int NUM_WORDS = 8;   // sync word plus channels
  localparam int CFG_IDX_W = 4;

  // Fixed byte positions in a frame
  localparam logic [POS_W-1:0] FLAGS_POS = POS_W'(21);
  localparam logic [POS_W-1:0] CHECK_POS = POS_W'(22);

  // Register reset values
  localparam logic [WORD_W-1:0] TIMEOUT_RST  = 16'd500;
  localparam logic [WORD_W-1:0] SYNC_RST     = 16'hABCD;
  localparam logic [WORD_W-1:0] FS_THR_RST   = 16'd1000;
  localparam logic [WORD_W-1:0] CENTER_RST   = 16'd1500;
  localparam logic [WORD_W-1:0] IDLE_SAT     = 16'hFFFF;

  // Item kinds on the input tuser bit
  typedef enum logic {
    OP_BYTE = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  // Register indexes on the configuration channel
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIMEOUT  = 4'd0,
    REG_SYNC     = 4'd1,
    REG_FS_THR   = 4'd2,
    REG_CENTER   = 4'd3
  } reg_idx_t;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [NUM_CHANS-1:0] chan_vec_t;

  // Frame completion event from the assembler
  typedef struct packed {
    logic frame_end;
    logic frame_ok;
  } frame_evt_t;

  // Live configuration
  typedef struct packed {
    word_t timeout_ms;
    word_t sync_word;
    word_t failsafe_throttle;
    word_t center_value;
  } cfg_t;

endpackage

### sv/rcpr_frame_asm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpr_frame_asm
// Stages frame bytes, keeps the running XOR and checks the frame at its end.
// ----------------------------------------------------------------------------
module rcpr_frame_asm
  import rcpr_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  op_t               op,
  input  logic [BYTE_W-1:0] data_byte,
  input  word_t             sync_word,
  output frame_evt_t        evt,
  output chan_vec_t         staged_chans,
  output logic [BYTE_W-1:0] staged_flags
);

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] xor_r, xor_nxt;
  word_t             words_r [NUM_WORDS];
  logic [BYTE_W-1:0] flags_r;
  logic [BYTE_W-1:0] check_r;
  logic [BYTE_W-1:0] check_eff;
  logic              is_byte;
  logic              last_byte;

  assign is_byte   = advance && (op == OP_BYTE);
  assign last_byte = (pos_r >= LAST_POS);

  // check byte may be the last of a short frame
  assign check_eff = (pos_r == CHECK_POS) ? data_byte : check_r;

  assign evt.frame_end = is_byte && last_byte;
  assign evt.frame_ok  = (words_r[0] == sync_word) && (xor_r == check_eff);

  always_comb begin
    pos_nxt = pos_r;
    xor_nxt = xor_r;
    if (is_byte) begin
      if (last_byte) begin
        pos_nxt = '0;
        xor_nxt = '0;
      end else begin
        pos_nxt = pos_r + POS_W'(1);
        if (pos_r < CHECK_POS) begin
          xor_nxt = xor_r ^ data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      xor_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  // staging payload, no reset
  always_ff @(posedge clk) begin
    if (is_byte) begin
      if (!pos_r[POS_W-1]) begin
        if (pos_r[0]) begin
          words_r[pos_r[3:1]][15:8] <= data_byte;
        end else begin
          words_r[pos_r[3:1]][7:0] <= data_byte;
        end
      end
      if (pos_r == FLAGS_POS) begin
        flags_r <= data_byte;
      end
      if (pos_r == CHECK_POS) begin
        check_r <= data_byte;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CHANS; i++) begin
      staged_chans[i] = words_r[i+1];
    end
  end

  assign staged_flags = flags_r;

  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    evt.frame_end |=> (pos_r == '0) && (xor_r == '0))
    else $error("frame end did not restart the position");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LAST_POS)
    else $error("byte position beyond frame length");

endmodule

### sv/rcpr_link_mon.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcpr_link_mon
// Channel latch, idle timer, failsafe forcing and lost counter.
// ----------------------------------------------------------------------------
module rcpr_link_mon
  import rcpr_pkg::*;
#(
  parameter int CHANNEL_COUNT = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  op_t               op,
  input  frame_evt_t        evt,
  input  chan_vec_t         staged_chans,
  input  logic [BYTE_W-1:0] staged_flags,
  input  cfg_t              cfg,
  output chan_vec_t         chans_nxt,
  output logic              good_nxt,
  output logic              bad_nxt,
  output logic              failsafe_nxt,
  output logic [LOST_W-1:0] lost_nxt,
  output logic [BYTE_W-1:0] flags_nxt
);

  chan_vec_t         chans_r;
  word_t             idle_r, idle_nxt, idle_inc;
  logic [LOST_W-1:0] lost_r;
  logic [BYTE_W-1:0] flags_r;
  logic              is_tick;

  assign is_tick  = advance && (op == OP_TICK);
  assign idle_inc = (idle_r == IDLE_SAT) ? idle_r : idle_r + WORD_W'(1);

  always_comb begin
    chans_nxt = chans_r;
    idle_nxt  = idle_r;
    lost_nxt  = lost_r;
    flags_nxt = flags_r;
    good_nxt  = 1'b0;
    bad_nxt   = 1'b0;
    if (evt.frame_end) begin
      if (evt.frame_ok) begin
        for (int i = 0; i < NUM_CHANS; i++) begin
          if (i < CHANNEL_COUNT) begin
            chans_nxt[i] = staged_chans[i];
          end
        end
        flags_nxt = staged_flags;
        idle_nxt  = '0;
        good_nxt  = 1'b1;
      end else begin
        lost_nxt = lost_r + LOST_W'(1);
        bad_nxt  = 1'b1;
      end
    end else if (is_tick) begin
      idle_nxt = idle_inc;
      if (idle_inc > cfg.timeout_ms) begin
        lost_nxt = lost_r + LOST_W'(1);
        for (int i = 0; i < NUM_CHANS; i++) begin
          chans_nxt[i] = (i == 0) ? cfg.failsafe_throttle : cfg.center_value;
        end
      end
    end
  end

  assign failsafe_nxt = (idle_nxt > cfg.timeout_ms);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chans_r <= {NUM_CHANS{CENTER_RST}};
      idle_r  <= '0;
      lost_r  <= '0;
      flags_r <= '0;
    end else begin
      chans_r <= chans_nxt;
      idle_r  <= idle_nxt;
      lost_r  <= lost_nxt;
      flags_r <= flags_nxt;
    end
  end

  a_lost_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (lost_r == $past(lost_r)) || (lost_r == $past(lost_r) + LOST_W'(1)))
    else $error("lost counter moved by more than one");

  a_good_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (evt.frame_end && evt.frame_ok) |=> (idle_r == '0))
    else $error("valid frame did not clear idle timer");

endmodule

### sv/rc_packet_receiver_failsafe_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_packet_receiver_failsafe_unit
// Frame receiver for an RC link with idle timeout and failsafe channels.
// ----------------------------------------------------------------------------
// Path: input request to result on out_* through the input register,
//   then the result register.
// Throughput: one request per cycle while out_tready takes each result; the
//   state update is a single pass of logic between the input and result registers.
// Reset: rst_n synchronous, active low. Channels return to 1500, timer,
//   lost counter, flags and frame position to zero, registers to defaults.
// ----------------------------------------------------------------------------
module rc_packet_receiver_failsafe_unit
  import rcpr_pkg::*;
#(
  parameter int FRAME_BYTES   = 32,  // 23..32
  parameter int CHANNEL_COUNT = 7    // channels taken from a good frame, 1..7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] data_byte
  input  logic                 in_tuser,   // [0] opcode (0 byte, 1 tick)
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [15:0] throttle, [31:16] yaw, [47:32] roll, [63:48] pitch,
  // [79:64] aux_one, [95:80] aux_two, [111:96] aux_three,
  // [143:112] lost_total, [151:144] tx_flags
  output logic [151:0]         out_tdata,
  output logic [2:0]           out_tuser,  // [0] frame_good, [1] frame_bad, [2] failsafe_on
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data
);

  // Input register
  logic              in_valid_r;
  op_t               in_op_r;
  logic [BYTE_W-1:0] in_byte_r;

  // Result register
  logic              out_valid_r;
  chan_vec_t         out_chans_r;
  logic              out_good_r;
  logic              out_bad_r;
  logic              out_fs_r;
  logic [LOST_W-1:0] out_lost_r;
  logic [BYTE_W-1:0] out_flags_r;

  cfg_t cfg_r;

  // An item moves from the input register into the result register when the
  // result slot is free or being emptied; the state updates on that move.
  logic advance;

  frame_evt_t        evt;
  chan_vec_t         staged_chans;
  logic [BYTE_W-1:0] staged_flags;
  chan_vec_t         chans_nxt;
  logic              good_nxt, bad_nxt, fs_nxt;
  logic [LOST_W-1:0] lost_nxt;
  logic [BYTE_W-1:0] flags_nxt;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_ms        <= TIMEOUT_RST;
      cfg_r.sync_word         <= SYNC_RST;
      cfg_r.failsafe_throttle <= FS_THR_RST;
      cfg_r.center_value      <= CENTER_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TIMEOUT: cfg_r.timeout_ms        <= cfg_data;
        REG_SYNC:    cfg_r.sync_word         <= cfg_data;
        REG_FS_THR:  cfg_r.failsafe_throttle <= cfg_data;
        REG_CENTER:  cfg_r.center_value      <= cfg_data;
        default: ;  // writes beyond the register list are dropped
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_op_r   <= op_t'(in_tuser);
      in_byte_r <= in_tdata;
    end
  end

  rcpr_frame_asm #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame_asm (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .op           (in_op_r),
    .data_byte    (in_byte_r),
    .sync_word    (cfg_r.sync_word),
    .evt          (evt),
    .staged_chans (staged_chans),
    .staged_flags (staged_flags)
  );

  rcpr_link_mon #(
    .CHANNEL_COUNT (CHANNEL_COUNT)
  ) u_link_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .advance      (advance),
    .op           (in_op_r),
    .evt          (evt),
    .staged_chans (staged_chans),
    .staged_flags (staged_flags),
    .cfg          (cfg_r),
    .chans_nxt    (chans_nxt),
    .good_nxt     (good_nxt),
    .bad_nxt      (bad_nxt),
    .failsafe_nxt (fs_nxt),
    .lost_nxt     (lost_nxt),
    .flags_nxt    (flags_nxt)
  );

  // Result register: holds while the consumer stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_chans_r <= chans_nxt;
      out_good_r  <= good_nxt;
      out_bad_r   <= bad_nxt;
      out_fs_r    <= fs_nxt;
      out_lost_r  <= lost_nxt;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_flags_r, out_lost_r, out_chans_r};
  assign out_tuser  = {out_fs_r, out_bad_r, out_good_r};

  a_good_bad_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_good_r && out_bad_r))
    else $error("frame reported both good and bad");

  a_good_no_fs: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_good_r) |-> !out_fs_r)
    else $error("failsafe still on after a good frame");

endmodule
